// ===== sv/lcst_pkg.sv =====
`timescale 1ns / 1ps

package lcst_pkg;

	// Lane table size
	localparam int LANES     = 4;
	localparam int MAX_LANES = (LANES < 4) ? LANES : 4;

	// Field and datapath widths
	localparam int TIME_W       = 16;
	localparam int DIST_W       = 16;
	localparam int SPEED_W      = 22;
	localparam int DIVIDEND_W   = SPEED_W;
	localparam int LENGTH_W     = 32;
	localparam int INFO_W       = 32;
	localparam int STEPS_W      = 6;
	localparam int QUO_W        = 16;
	localparam int RECIP_W      = 23;
	localparam int RECIP_SHIFT  = SPEED_W + 6;
	localparam int RECIP_PROD_W = SPEED_W + RECIP_W;

	// Stream and register bus widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 56;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;

	// Arithmetic constants
	localparam logic [SPEED_W-1:0] COIL_SCALE    = SPEED_W'(36);
	localparam logic [TIME_W-1:0]  ZERO_TIME_SUB = TIME_W'(1000);
	localparam logic [STEPS_W-1:0] DIV_STEPS_SPD = STEPS_W'(SPEED_W);
	// 2^28/36 rounded up: exact floor(n/36) for any 22-bit n
	localparam logic [RECIP_W-1:0] RECIP_36      = RECIP_W'(7456541);

	// Register indexes (address bits 5:3)
	localparam logic [2:0] REG_IDS       = 3'd0;
	localparam logic [2:0] REG_LANES     = 3'd1;
	localparam logic [2:0] REG_DISTANCES = 3'd2;
	localparam logic [2:0] REG_HEIGHTS   = 3'd3;
	localparam logic [2:0] REG_MODES     = 3'd4;

	// Item codes
	localparam logic [1:0] POS_FRONT    = 2'd0;
	localparam logic [1:0] POS_BEHIND   = 2'd1;
	localparam logic [1:0] EVT_ENTER    = 2'd0;
	localparam logic [1:0] EVT_LEAVE    = 2'd1;
	localparam logic [1:0] DIR_CORRECT  = 2'd0;
	localparam logic [1:0] DIR_NONE     = 2'd2;
	localparam logic [1:0] STEP_NONE    = 2'd0;
	localparam logic [1:0] STEP_FIRST   = 2'd1;
	localparam logic [1:0] STEP_SECOND  = 2'd2;
	localparam logic [1:0] ST_HANDLED   = 2'd0;
	localparam logic [1:0] ST_NO_LANE   = 2'd1;
	localparam logic [1:0] ST_BAD_POS   = 2'd2;
	localparam logic [1:0] CMODE_NO_SPD = 2'd1;
	localparam logic [1:0] CMODE_SPD    = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] event_time;
		logic [1:0]        travel_direction;
		logic [1:0]        coil_event;
		logic [1:0]        coil_position;
		logic [7:0]        detector_lane;
		logic [7:0]        port_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [7:0]        snap_port;
		logic [1:0]        snap_direction;
		logic [INFO_W-1:0] vehicle_info;
		logic [1:0]        snap_step;
		logic [1:0]        lane_index;
		logic              snap_fire;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic lookup;
		logic div_start;
		logic take_speed;
		logic len_quo;
		logic len_split;
		logic len_mul;
		logic len_frac;
		logic take_len;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_speed;
		logic need_length;
		logic div_done;
	} sts_t;

endpackage

// ===== sv/lcst_div.sv =====
`timescale 1ns / 1ps

module lcst_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lcst_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [lcst_pkg::TIME_W-1:0]       divisor,
	input  logic [lcst_pkg::STEPS_W-1:0]      steps,
	output logic                              done,
	output logic [lcst_pkg::DIVIDEND_W-1:0]   quotient
);
	import lcst_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEPS_W-1:0]    cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [TIME_W-1:0]     rem_q;
	logic [TIME_W-1:0]     dsr_q;
	logic [TIME_W:0]       trial;
	logic                  qbit;
	logic [TIME_W-1:0]     rem_n;

	// One restoring step: bring in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dq_q[DIVIDEND_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
		rem_n = qbit ? TIME_W'(trial - {1'b0, dsr_q}) : trial[TIME_W-1:0];
	end

	// Control: count steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEPS_W'(1);
			if (cnt_q == STEPS_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift dividend out and quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVIDEND_W-2:0], qbit};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== sv/lcst_dp.sv =====
`timescale 1ns / 1ps

module lcst_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lcst_pkg::PADDR_W-1:0] paddr,
	input  logic [lcst_pkg::PDATA_W-1:0] pwdata,
	output logic [lcst_pkg::PDATA_W-1:0] prdata,
	input  lcst_pkg::in_item_t           s_item,
	input  lcst_pkg::cmd_t               cmd,
	output lcst_pkg::sts_t               sts,
	output lcst_pkg::out_item_t          m_item
);
	import lcst_pkg::*;

	// Configuration registers
	logic [31:0]  ids_q;
	logic [2:0]   lanes_q;
	logic [63:0]  dists_q;
	logic [63:0]  heights_q;
	logic [31:0]  modes_q;

	// Shared coil state
	logic [TIME_W-1:0]   fe_q;
	logic [TIME_W-1:0]   fl_q;
	logic [SPEED_W-1:0]  st_spd_q;
	logic [LENGTH_W-1:0] st_len_q;

	// Item and per-item working registers
	in_item_t              item_q;
	logic                  found_q;
	logic [1:0]            lane_q;
	logic [4:0]            mode_q;
	logic [DIST_W-1:0]     dist_q;
	logic [DIST_W-1:0]     height_q;
	logic [TIME_W-1:0]     den_q;
	logic [TIME_W-1:0]     dt_q;
	logic                  sc_q;
	logic                  need_spd_q;
	logic                  need_len_q;
	logic [SPEED_W-1:0]    speed_q;
	logic [QUO_W-1:0]      quo_q;
	logic [5:0]            rem36_q;
	logic [LENGTH_W-1:0]   ad_q;
	logic [SPEED_W-1:0]    bd_q;
	logic [QUO_W-1:0]      frac_q;
	logic [LENGTH_W-1:0]   len_q;
	out_item_t             out_q;

	// Lookup signals
	logic [2:0]        lim;
	logic              found;
	logic [1:0]        idx;
	logic [7:0]        mode;
	logic              sc;
	logic [TIME_W-1:0] den_raw;
	logic [1:0]        first;
	logic              need_len;
	logic              need_spd;

	// Divider hookup
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [TIME_W-1:0]     div_divisor;
	logic [STEPS_W-1:0]    div_steps;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_q;

	// Reciprocal divide by 36
	logic [SPEED_W-1:0]      recip_in;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [QUO_W-1:0]        recip_quo;

	// Finish signals
	logic [SPEED_W-1:0]  spd_n;
	logic [LENGTH_W-1:0] len_n;
	logic [TIME_W-1:0]   fe_n;
	logic [TIME_W-1:0]   fl_n;
	logic                hit;
	logic [1:0]          first_f;
	out_item_t           res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q     <= '0;
			lanes_q   <= '0;
			dists_q   <= '0;
			heights_q <= '0;
			modes_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[5:3])
				REG_IDS:       ids_q     <= pwdata[31:0];
				REG_LANES:     lanes_q   <= pwdata[2:0];
				REG_DISTANCES: dists_q   <= pwdata;
				REG_HEIGHTS:   heights_q <= pwdata;
				REG_MODES:     modes_q   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (paddr[5:3])
			REG_IDS:       prdata = {32'd0, ids_q};
			REG_LANES:     prdata = {61'd0, lanes_q};
			REG_DISTANCES: prdata = dists_q;
			REG_HEIGHTS:   prdata = heights_q;
			REG_MODES:     prdata = {32'd0, modes_q};
			default:       prdata = '0;
		endcase
	end

	// Map the detector lane to the first matching configured lane
	always_comb begin
		lim = lanes_q;
		if (lim > 3'(MAX_LANES)) lim = 3'(MAX_LANES);
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < 4; i++) begin
			if (!found && (3'(i) < lim) && (ids_q[8*i +: 8] != 8'd0) &&
				((ids_q[8*i +: 8] - 8'd1) == item_q.detector_lane)) begin
				found = 1'b1;
				idx   = 2'(i);
			end
		end
		mode    = modes_q[8*idx +: 8];
		sc      = mode[0] && ((mode[2:1] == CMODE_NO_SPD) || (mode[2:1] == CMODE_SPD));
		den_raw = sc ? (item_q.event_time - fe_q) : item_q.event_time;
		first   = (item_q.travel_direction != DIR_CORRECT) ? POS_BEHIND : POS_FRONT;
		need_len = found && sc && (item_q.coil_position == POS_BEHIND) &&
			(item_q.coil_event == EVT_ENTER);
		need_spd = need_len || (found && !sc && (item_q.coil_event == EVT_ENTER) &&
			((item_q.coil_position == POS_FRONT) || (item_q.coil_position == POS_BEHIND)) &&
			(item_q.coil_position != first));
	end

	// Quotient by 36 of the speed or of the remainder product
	assign recip_in   = cmd.len_frac ? bd_q : speed_q;
	assign recip_prod = RECIP_PROD_W'(recip_in) * RECIP_PROD_W'(RECIP_36);
	assign recip_quo  = recip_prod[RECIP_SHIFT +: QUO_W];

	// Hold the item and the looked-up lane parameters
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= s_item;
		if (cmd.lookup) begin
			found_q    <= found;
			lane_q     <= idx;
			mode_q     <= mode[4:0];
			dist_q     <= dists_q[16*idx +: 16];
			height_q   <= heights_q[16*idx +: 16];
			den_q      <= (den_raw == '0) ? ZERO_TIME_SUB : den_raw;
			dt_q       <= fl_q - fe_q;
			sc_q       <= sc;
			need_spd_q <= need_spd;
			need_len_q <= need_len;
		end
		if (cmd.take_speed) speed_q <= div_q[SPEED_W-1:0];
		// Length is (speed/36)*dt + ((speed%36)*dt)/36, less the height
		if (cmd.len_quo) quo_q <= recip_quo;
		if (cmd.len_split) begin
			rem36_q <= 6'(speed_q - SPEED_W'(quo_q) * COIL_SCALE);
			ad_q    <= LENGTH_W'(quo_q) * LENGTH_W'(dt_q);
		end
		if (cmd.len_mul) bd_q <= SPEED_W'(rem36_q) * SPEED_W'(dt_q);
		if (cmd.len_frac) frac_q <= recip_quo;
		if (cmd.take_len) len_q <= ad_q + LENGTH_W'(frac_q) - LENGTH_W'(height_q);
		if (cmd.finish) out_q <= res;
	end

	// Speed is dist*36/elapsed
	assign div_dividend = SPEED_W'(dist_q) * COIL_SCALE;
	assign div_divisor  = den_q;
	assign div_steps    = DIV_STEPS_SPD;

	lcst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_q)
	);

	// Build the result and the next coil state
	always_comb begin
		spd_n   = st_spd_q;
		len_n   = st_len_q;
		fe_n    = fe_q;
		fl_n    = fl_q;
		hit     = 1'b0;
		first_f = (item_q.travel_direction != DIR_CORRECT) ? POS_BEHIND : POS_FRONT;
		res     = '0;
		res.lane_index = found_q ? lane_q : 2'd0;
		if (!found_q) begin
			res.status = ST_NO_LANE;
		end else if (sc_q) begin
			case ({item_q.coil_position, item_q.coil_event})
				{POS_FRONT, EVT_ENTER}: begin
					spd_n = '0;
					len_n = '0;
					fe_n  = item_q.event_time;
					hit   = !mode_q[3] && !mode_q[4];
				end
				{POS_FRONT, EVT_LEAVE}: begin
					fl_n = item_q.event_time;
					hit  = !mode_q[3] && mode_q[4];
				end
				{POS_BEHIND, EVT_ENTER}: begin
					spd_n = speed_q;
					len_n = len_q;
					hit   = mode_q[3] && !mode_q[4];
				end
				{POS_BEHIND, EVT_LEAVE}: begin
					hit = mode_q[3] && mode_q[4];
				end
				default: ;
			endcase
			if (hit) begin
				res.snap_fire      = 1'b1;
				res.snap_step      = STEP_FIRST;
				res.snap_direction = DIR_NONE;
				if (mode_q[2:1] == CMODE_SPD)
					res.vehicle_info = {len_n[15:0], 16'd0} | INFO_W'(spd_n);
			end
		end else if ((item_q.coil_position != POS_FRONT) &&
			(item_q.coil_position != POS_BEHIND)) begin
			res.status = ST_BAD_POS;
		end else if (item_q.coil_event == EVT_ENTER) begin
			res.snap_fire      = 1'b1;
			res.snap_direction = item_q.travel_direction;
			if (item_q.coil_position == first_f) begin
				res.snap_step = STEP_FIRST;
			end else begin
				res.snap_step    = STEP_SECOND;
				res.vehicle_info = INFO_W'(speed_q);
			end
		end
		res.snap_port = res.snap_fire ? item_q.port_id : 8'd0;
	end

	// Commit the coil state when the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q     <= '0;
			fl_q     <= '0;
			st_spd_q <= '0;
			st_len_q <= '0;
		end else if (cmd.finish) begin
			fe_q     <= fe_n;
			fl_q     <= fl_n;
			st_spd_q <= spd_n;
			st_len_q <= len_n;
		end
	end

	assign sts.need_speed  = need_spd_q;
	assign sts.need_length = need_len_q;
	assign sts.div_done    = div_done;
	assign m_item          = out_q;

endmodule

// ===== sv/lcst_ctrl.sv =====
`timescale 1ns / 1ps

module lcst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	output logic             s_ready,
	output logic             m_valid,
	input  logic             m_ready,
	input  lcst_pkg::sts_t   sts,
	output lcst_pkg::cmd_t   cmd
);
	import lcst_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_LOOKUP    = 10'b00_0000_0010,
		ST_PREP      = 10'b00_0000_0100,
		ST_DIV_SPD   = 10'b00_0000_1000,
		ST_LEN_QUO   = 10'b00_0001_0000,
		ST_LEN_SPLIT = 10'b00_0010_0000,
		ST_LEN_MUL   = 10'b00_0100_0000,
		ST_LEN_FRAC  = 10'b00_1000_0000,
		ST_LEN_SUM   = 10'b01_0000_0000,
		ST_FINISH    = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_vld_q;

	// Sequence one item through lookup, speed division, length steps and result load
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.load_item = 1'b1;
					state_n       = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_n    = ST_PREP;
			end
			ST_PREP: begin
				if (sts.need_speed) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV_SPD;
				end else begin
					state_n = ST_FINISH;
				end
			end
			ST_DIV_SPD: begin
				if (sts.div_done) begin
					cmd.take_speed = 1'b1;
					state_n        = sts.need_length ? ST_LEN_QUO : ST_FINISH;
				end
			end
			ST_LEN_QUO: begin
				cmd.len_quo = 1'b1;
				state_n     = ST_LEN_SPLIT;
			end
			ST_LEN_SPLIT: begin
				cmd.len_split = 1'b1;
				state_n       = ST_LEN_MUL;
			end
			ST_LEN_MUL: begin
				cmd.len_mul = 1'b1;
				state_n     = ST_LEN_FRAC;
			end
			ST_LEN_FRAC: begin
				cmd.len_frac = 1'b1;
				state_n      = ST_LEN_SUM;
			end
			ST_LEN_SUM: begin
				cmd.take_len = 1'b1;
				state_n      = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_vld_q || m_ready) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Advance state; hold the output valid until the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.finish) out_vld_q <= 1'b1;
			else if (m_ready) out_vld_q <= 1'b0;
		end
	end

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = out_vld_q;

endmodule

// ===== sv/loop_coil_speed_snap_trigger.sv =====
`timescale 1ns / 1ps

// Loop-coil snap trigger: takes one coil event per item, maps its detector lane
// to a configured lane and returns one result item with the capture decision,
// step, speed or packed length/speed, and a status. Items are handled one at a
// time; the result sits in an output register, so the next item is taken while
// it waits. An item needing no arithmetic skips the divider; a dual-coil second
// step makes one 22-step pass of the restoring divider for distance*36/elapsed;
// a single-coil behind-enter makes the speed pass, then five steps that divide
// speed*dt by 36 through a reciprocal multiply: quotient of speed by 36, split
// and multiply by dt, quotient of the remainder product, sum less the height.
// Registers sit at byte address 8*index on the 64-bit configuration port; the
// user must write them only while idle, as the block does not enforce this.

module loop_coil_speed_snap_trigger (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lcst_pkg::PADDR_W-1:0]   paddr,
	input  logic [lcst_pkg::PDATA_W-1:0]   pwdata,
	output logic [lcst_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// port_id, detector_lane, coil_position, coil_event, travel_direction, event_time
	input  logic [lcst_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// snap_fire, lane_index, snap_step, vehicle_info, snap_direction, snap_port, status
	output logic [lcst_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import lcst_pkg::*;

	localparam int IN_BITS  = $bits(in_item_t);
	localparam int OUT_BITS = $bits(out_item_t);

	cmd_t      cmd;
	sts_t      sts;
	in_item_t  s_item;
	out_item_t m_item;

	// Unpack and pack the stream payloads
	assign s_item       = in_item_t'(s_axis_tdata[IN_BITS-1:0]);
	assign m_axis_tdata = {{(M_TDATA_W-OUT_BITS){1'b0}}, m_item};
	assign pready       = 1'b1;

	lcst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lcst_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.s_item  (s_item),
		.cmd     (cmd),
		.sts     (sts),
		.m_item  (m_item)
	);

endmodule

// ===== sv/lcst_chk.sv =====
`timescale 1ns / 1ps

module lcst_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [lcst_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	// One item at a time: after an accept, no new item while it is in lookup and prep
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken again too soon after an accept");

	// A result cannot appear in the cycle right after an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared one cycle after accept");

	// Stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// Stalled result payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

endmodule

bind loop_coil_speed_snap_trigger lcst_chk u_lcst_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
